// File: src/multires_knn_vote_top_defines.svh
// ----------------------------------------------------------------------------
// multires_knn_vote_top_defines
// Assertion macros shared by the k-NN vote block. Each macro expects clk and
// arst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef MULTIRES_KNN_VOTE_TOP_DEFINES_SVH
`define MULTIRES_KNN_VOTE_TOP_DEFINES_SVH

// Check in the same cycle: when pre holds, post holds too.
`define MKV_ASSERT_SAME(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Check in the cycle after: when pre holds, post holds at the next edge.
`define MKV_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: src/mkv_pkg.sv
// ----------------------------------------------------------------------------
// mkv_pkg
// Types, widths and codes shared by the k-NN vote block.
// ----------------------------------------------------------------------------
`default_nettype none

package mkv_pkg;

	localparam int unsigned MKV_TOP_K       = 5;
	localparam int unsigned MKV_NUM_CLASSES = 10;

	localparam int unsigned D0_W    = 10;
	localparam int unsigned D1_W    = 12;
	localparam int unsigned D2_W    = 13;
	localparam int unsigned D3_W    = 14;
	localparam int unsigned D4_W    = 15;
	localparam int unsigned D5_W    = 16;
	localparam int unsigned D6_W    = 17;
	localparam int unsigned LABEL_W = 4;
	localparam int unsigned SCORE_W = 13;
	// seven terms of at most 11 bits each
	localparam int unsigned SUM_W   = 14;

	localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

	// action codes
	localparam logic ACT_CAND = 1'b0;
	localparam logic ACT_EOQ  = 1'b1;

	typedef struct packed {
		logic               action;
		logic [D0_W-1:0]    dist_stage0;
		logic [D1_W-1:0]    dist_stage1;
		logic [D2_W-1:0]    dist_stage2;
		logic [D3_W-1:0]    dist_stage3;
		logic [D4_W-1:0]    dist_stage4;
		logic [D5_W-1:0]    dist_stage5;
		logic [D6_W-1:0]    dist_stage6;
		logic [LABEL_W-1:0] cand_label;
	} cand_item_t;

	typedef struct packed {
		logic               nn_found;
		logic [LABEL_W-1:0] nn_label;
		logic [LABEL_W-1:0] knn_label;
	} res_item_t;

	// one entry of the sorted list as seen by its neighbor
	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic [LABEL_W-1:0] label;
		logic               keep;
	} lane_t;

	typedef struct packed {
		logic               start;
		logic               nn_found;
		logic [LABEL_W-1:0] nn_label;
	} vote_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} vote_sts_t;

	typedef enum logic [1:0] {
		VS_IDLE,
		VS_ACC,
		VS_MAX,
		VS_DONE
	} vote_state_t;

endpackage

`default_nettype wire

// File: src/mkv_lane.sv
// ----------------------------------------------------------------------------
// mkv_lane
// One entry of the sorted top-k list with its compare and shift/insert logic.
// ----------------------------------------------------------------------------
`default_nettype none

module mkv_lane
	import mkv_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               load,
	input  wire logic               occupied,
	input  wire logic               head,
	input  wire logic [SCORE_W-1:0] score,
	input  wire logic [LABEL_W-1:0] label,
	input  wire lane_t              prev,
	output lane_t                   lane
);

	logic [SCORE_W-1:0] score_q;
	logic [LABEL_W-1:0] label_q;
	logic               keep;

	// an occupied entry stays put when it is not above the new score (ties keep order)
	assign keep = occupied && (score_q <= score);

	always_ff @(posedge clk) begin
		if (load && !keep) begin
			if (head || prev.keep) begin
				score_q <= score;
				label_q <= label;
			end else begin
				score_q <= prev.score;
				label_q <= prev.label;
			end
		end
	end

	assign lane = '{score: score_q, label: label_q, keep: keep};

endmodule

`default_nettype wire

// File: src/mkv_vote.sv
// ----------------------------------------------------------------------------
// mkv_vote
// Merge stage: walks the list one entry per cycle to build class weights,
// then walks the classes to pick the heaviest, lowest class on ties.
// ----------------------------------------------------------------------------
`default_nettype none

module mkv_vote
	import mkv_pkg::*;
#(
	parameter int unsigned TOP_K       = MKV_TOP_K,
	parameter int unsigned NUM_CLASSES = MKV_NUM_CLASSES
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire vote_req_t                       req,
	input  wire logic [$clog2(TOP_K+1)-1:0]      count,
	input  wire logic [TOP_K-1:0][LABEL_W-1:0]   labels,
	input  wire logic                            take,
	output vote_sts_t                            sts,
	output res_item_t                            result
);

	localparam int unsigned CNT_W  = $clog2(TOP_K + 1);
	localparam int unsigned LIDX_W = (TOP_K > 1) ? $clog2(TOP_K) : 1;
	localparam int unsigned CIDX_W = $clog2(NUM_CLASSES);
	localparam int unsigned VOTE_W = $clog2(TOP_K * (TOP_K + 1) / 2 + 1);

	vote_state_t                 state_q, state_d;
	logic [TOP_K-1:0][LABEL_W-1:0] labels_q;
	logic [CNT_W-1:0]            count_q;
	logic                        nn_found_q;
	logic [LABEL_W-1:0]          nn_label_q;
	logic [VOTE_W-1:0]           votes_q [NUM_CLASSES];
	logic [LIDX_W-1:0]           idx_q;
	logic [CIDX_W-1:0]           cls_q;
	logic [CIDX_W-1:0]           win_q;
	logic [VOTE_W-1:0]           win_votes_q;

	logic [LABEL_W-1:0]          cur_label;
	logic [CIDX_W-1:0]           cur_cls;
	logic [CIDX_W-1:0]           rd_addr;
	logic [VOTE_W-1:0]           rd_votes;
	logic [VOTE_W-1:0]           weight;
	logic                        acc_en;
	logic                        lane_last;
	logic                        cls_last;

	assign cur_label = labels_q[idx_q];
	assign cur_cls   = cur_label[CIDX_W-1:0];
	assign weight    = VOTE_W'(TOP_K) - VOTE_W'(idx_q);
	assign acc_en    = (CNT_W'(idx_q) < count_q) &&
		({1'b0, cur_label} < (LABEL_W + 1)'(NUM_CLASSES));
	assign lane_last = (idx_q == LIDX_W'(TOP_K - 1));
	assign cls_last  = (cls_q == CIDX_W'(NUM_CLASSES - 1));

	// single read port into the class weights
	assign rd_addr  = (state_q == VS_ACC) ? cur_cls : cls_q;
	assign rd_votes = votes_q[rd_addr];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= VS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		sts.busy = (state_q != VS_IDLE);
		sts.done = (state_q == VS_DONE);
		case (state_q)
			VS_IDLE: begin
				if (req.start) state_d = VS_ACC;
			end
			VS_ACC: begin
				if (lane_last) state_d = VS_MAX;
			end
			VS_MAX: begin
				if (cls_last) state_d = VS_DONE;
			end
			VS_DONE: begin
				if (take) state_d = VS_IDLE;
			end
			default: state_d = VS_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			VS_IDLE: begin
				if (req.start) begin
					labels_q    <= labels;
					count_q     <= count;
					nn_found_q  <= req.nn_found;
					nn_label_q  <= req.nn_label;
					idx_q       <= '0;
					cls_q       <= '0;
					win_q       <= '0;
					win_votes_q <= '0;
					for (int c = 0; c < NUM_CLASSES; c++) begin
						votes_q[c] <= '0;
					end
				end
			end
			VS_ACC: begin
				if (acc_en) votes_q[cur_cls] <= rd_votes + weight;
				idx_q <= idx_q + LIDX_W'(1);
			end
			VS_MAX: begin
				if (rd_votes > win_votes_q) begin
					win_q       <= cls_q;
					win_votes_q <= rd_votes;
				end
				cls_q <= cls_q + CIDX_W'(1);
			end
			default: begin
			end
		endcase
	end

	assign result = '{
		nn_found:  nn_found_q,
		nn_label:  nn_label_q,
		knn_label: LABEL_W'(win_q)
	};

endmodule

`default_nettype wire

// File: src/multires_knn_vote_top.sv
// ----------------------------------------------------------------------------
// multires_knn_vote_top
// Multi-resolution nearest neighbor with a rank-weighted top-k vote.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Handshake               Payload
//   cand     in   cand_valid/cand_stall   cand_item_t: action, 7 distances, label
//   res      out  res_valid/res_stall     res_item_t: nn_found, nn_label, knn_label
//
// On a candidate transfer the score is formed and registered, then all TOP_K list
// lanes compare and shift/insert in parallel the next cycle. An end-of-query
// transfer holds cand_stall while it sits in stage 1 and while the vote unit
// walks the list one lane per cycle, then the classes one per cycle, then waits
// for the result register to free up.
// Reset (arst_n low) clears the stage-1 valid, the list count, the 1-NN valid flag,
// the vote sequencer and the result valid; list entries themselves are not cleared.
// res_stall holds the result word and delays the vote unit's hand-off into it.
// ----------------------------------------------------------------------------
`default_nettype none

module multires_knn_vote_top
	import mkv_pkg::*;
#(
	parameter int unsigned TOP_K       = MKV_TOP_K,
	parameter int unsigned NUM_CLASSES = MKV_NUM_CLASSES
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cand_valid,
	output logic            cand_stall,
	input  wire cand_item_t cand_data,
	output logic            res_valid,
	input  wire logic       res_stall,
	output res_item_t       res_data
);

`include "multires_knn_vote_top_defines.svh"

	localparam int unsigned CNT_W = $clog2(TOP_K + 1);

	// input transfer and score
	logic               cand_xfer;
	logic [SUM_W-1:0]   score_sum;
	logic [SCORE_W-1:0] score_sat;

	// stage 1: registered score
	logic               valid_s1;
	logic               action_s1;
	logic [SCORE_W-1:0] score_s1;
	logic [LABEL_W-1:0] label_s1;
	logic               cand_s1;
	logic               eoq_s1;

	// query state
	logic [CNT_W-1:0]   count_q;
	logic               best_valid_q;
	logic [SCORE_W-1:0] best_score_q;
	logic [LABEL_W-1:0] best_label_q;

	// lanes
	lane_t                       lane_bus [TOP_K];
	lane_t                       prev_bus [TOP_K];
	logic [TOP_K-1:0][LABEL_W-1:0] top_labels;

	// vote unit and result register
	vote_req_t  vreq;
	vote_sts_t  vsts;
	res_item_t  vres;
	logic       res_load;
	logic       res_valid_q;
	res_item_t  res_data_q;

	assign cand_xfer = cand_valid && !cand_stall;

	// Hold the input while the vote unit runs and while an end of query
	// sits in stage 1 waiting to hand off.
	assign cand_stall = vsts.busy || eoq_s1;

	// 2*d0 + d1>>1 + ... + d6>>6, each term truncated on its own
	assign score_sum = SUM_W'({cand_data.dist_stage0, 1'b0})
		+ SUM_W'(cand_data.dist_stage1[D1_W-1:1])
		+ SUM_W'(cand_data.dist_stage2[D2_W-1:2])
		+ SUM_W'(cand_data.dist_stage3[D3_W-1:3])
		+ SUM_W'(cand_data.dist_stage4[D4_W-1:4])
		+ SUM_W'(cand_data.dist_stage5[D5_W-1:5])
		+ SUM_W'(cand_data.dist_stage6[D6_W-1:6]);

	// saturate to the score width
	assign score_sat = (score_sum > SUM_W'(SCORE_MAX)) ? SCORE_MAX
		: score_sum[SCORE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cand_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (cand_xfer) begin
			action_s1 <= cand_data.action;
			score_s1  <= score_sat;
			label_s1  <= cand_data.cand_label;
		end
	end

	assign cand_s1 = valid_s1 && (action_s1 == ACT_CAND);
	assign eoq_s1  = valid_s1 && (action_s1 == ACT_EOQ);

	// Lanes: every entry compares against the new score at once; the first
	// entry that is empty or strictly above it takes the new candidate and the ones
	// behind it shift down by one.
	for (genvar i = 0; i < TOP_K; i++) begin : g_lane
		if (i == 0) begin : g_head
			assign prev_bus[i] = '0;
		end else begin : g_tail
			assign prev_bus[i] = lane_bus[i-1];
		end

		mkv_lane u_lane (
			.clk      (clk),
			.load     (cand_s1),
			.occupied (count_q > CNT_W'(i)),
			.head     (i == 0),
			.score    (score_s1),
			.label    (label_s1),
			.prev     (prev_bus[i]),
			.lane     (lane_bus[i])
		);

		assign top_labels[i] = lane_bus[i].label;
	end

	// List fill count and 1-NN tracking. The first candidate of a query always
	// wins the 1-NN; later ones only on a strictly lower score.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			best_valid_q <= 1'b0;
		end else if (eoq_s1) begin
			count_q      <= '0;
			best_valid_q <= 1'b0;
		end else if (cand_s1) begin
			if (count_q != CNT_W'(TOP_K)) count_q <= count_q + CNT_W'(1);
			best_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cand_s1 && (!best_valid_q || (score_s1 < best_score_q))) begin
			best_score_q <= score_s1;
			best_label_q <= label_s1;
		end
	end

	// Hand the query off to the vote unit; the list count and 1-NN flag clear the same edge.
	assign vreq = '{
		start:    eoq_s1,
		nn_found: best_valid_q,
		nn_label: best_valid_q ? best_label_q : '0
	};

	mkv_vote #(
		.TOP_K       (TOP_K),
		.NUM_CLASSES (NUM_CLASSES)
	) u_vote (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (vreq),
		.count  (count_q),
		.labels (top_labels),
		.take   (res_load),
		.sts    (vsts),
		.result (vres)
	);

	// Result register: load when empty or when the current word transfers.
	assign res_load = vsts.done && (!res_valid_q || !res_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) res_data_q <= vres;
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_data_q;

	// an end of query in stage 1 always finds the vote unit free
	`MKV_ASSERT_SAME(a_eoq_vote_free, eoq_s1, !vsts.busy, "end of query met a busy vote unit")
	// the list never claims more than TOP_K entries
	`MKV_ASSERT_SAME(a_count_range, 1'b1, count_q <= CNT_W'(TOP_K), "list count above TOP_K")
	// query state is cleared right after the hand-off
	`MKV_ASSERT_NEXT(a_query_clear, eoq_s1, (count_q == '0) && !best_valid_q, "query not cleared")
	// a finished vote stays put until the result register takes it
	`MKV_ASSERT_NEXT(a_vote_hold, vsts.done && !res_load, vsts.done, "vote result dropped")
	// a new result only ever comes from a finished vote
	`MKV_ASSERT_SAME(a_res_source, $rose(res_valid_q), $past(vsts.done), "result without vote")

endmodule

`default_nettype wire
